### rtl/divisor_sum_trial_division_macros.svh
// Assertion macros for the divisor-sum block.
`ifndef DIVISOR_SUM_TRIAL_DIVISION_MACROS_SVH
`define DIVISOR_SUM_TRIAL_DIVISION_MACROS_SVH

// Same-cycle implication, checked on clk, quiet during reset.
`define DST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, quiet during reset.
`define DST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dst_pkg.sv
// Shared types and constants for the divisor-sum block.
package dst_pkg;
	localparam int NUM_IN_BITS = 32;
	localparam int SUM_BITS    = 36;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_CHECK    = 6'b000010,
		ST_DIV_GO   = 6'b000100,
		ST_DIV_WAIT = 6'b001000,
		ST_ACC      = 6'b010000,
		ST_FIN      = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;       // take a new number, restart at d = 1
		logic start_div;  // launch n / d
		logic accum;      // add d and cofactor if exact, step d
		logic load_out;   // move the total into the output register
	} cmd_t;

	typedef struct packed {
		logic sq_gt_n;    // d*d > n, candidate range exhausted
		logic div_done;   // quotient and remainder valid
		logic out_free;   // output register can take a word
	} status_t;
endpackage

### rtl/dst_if.sv
// Stream interfaces for the number input and the divisor-sum output.
interface dst_in_if;
	import dst_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [NUM_IN_BITS-1:0] number;
	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

interface dst_out_if;
	import dst_pkg::*;
	logic                valid;
	logic                ready;
	logic [SUM_BITS-1:0] divisor_sum;
	modport source (output valid, output divisor_sum, input ready);
	modport sink   (input valid, input divisor_sum, output ready);
endinterface

### rtl/dst_div.sv
// Restoring divider, one quotient bit per cycle.
module dst_div #(
	parameter int NUMBER_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUMBER_BITS-1:0] dividend,
	input  logic [NUMBER_BITS-1:0] divisor,
	output logic                   done,
	output logic [NUMBER_BITS-1:0] quotient,
	output logic [NUMBER_BITS-1:0] remainder
);
	localparam int CW = $clog2(NUMBER_BITS);

	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [NUMBER_BITS-1:0] rem_q;
	logic [NUMBER_BITS-1:0] quo_q;
	logic [NUMBER_BITS:0]   shifted;
	logic [NUMBER_BITS+1:0] diff;
	logic                   ge;

	assign shifted = {rem_q, quo_q[NUMBER_BITS-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};
	assign ge      = ~diff[NUMBER_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUMBER_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NUMBER_BITS-1:0] : shifted[NUMBER_BITS-1:0];
			quo_q <= {quo_q[NUMBER_BITS-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

### rtl/dst_datapath.sv
// Datapath: number, candidate, square, running total, output register.
module dst_datapath #(
	parameter int NUMBER_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dst_pkg::cmd_t                 cmd,
	output dst_pkg::status_t              sts,
	input  logic [NUMBER_BITS-1:0]        number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dst_pkg::SUM_BITS-1:0]  out_sum
);
	import dst_pkg::*;

	logic [NUMBER_BITS-1:0] num_q;
	logic [NUMBER_BITS-1:0] cand_q;
	logic [NUMBER_BITS:0]   sq_q;
	logic [SUM_BITS-1:0]    total_q;
	logic [SUM_BITS-1:0]    sum_out_q;
	logic                   out_valid_q;
	logic [NUMBER_BITS-1:0] quo;
	logic [NUMBER_BITS-1:0] rem;
	logic                   div_done;
	logic [SUM_BITS-1:0]    cof_add;

	dst_div #(.NUMBER_BITS(NUMBER_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.start_div),
		.dividend  (num_q),
		.divisor   (cand_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	// cofactor counts once when d is the exact square root
	assign cof_add = (quo != cand_q) ? SUM_BITS'(quo) : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q   <= number;
			cand_q  <= NUMBER_BITS'(1);
			sq_q    <= (NUMBER_BITS+1)'(1);
			total_q <= '0;
		end else if (cmd.accum) begin
			if (rem == '0) begin
				total_q <= total_q + SUM_BITS'(cand_q) + cof_add;
			end
			// (d+1)^2 = d^2 + 2d + 1
			sq_q   <= sq_q + {cand_q, 1'b1};
			cand_q <= cand_q + 1'b1;
		end
		if (cmd.load_out) begin
			sum_out_q <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.sq_gt_n  = sq_q > {1'b0, num_q};
	assign sts.div_done = div_done;
	assign sts.out_free = ~out_valid_q | out_ready;
	assign out_valid    = out_valid_q;
	assign out_sum      = sum_out_q;
endmodule

### rtl/dst_ctrl.sv
// Controller: sequences candidate checks, divisions and accumulation.
module dst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dst_pkg::status_t sts,
	output dst_pkg::cmd_t    cmd
);
	import dst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = sts.sq_gt_n ? ST_FIN : ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.start_div = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.accum = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

### rtl/divisor_sum_trial_division.sv
// Divisor-sum unit top level: sigma_1(n) by paired trial division.
// Per number: checks d = 1, 2, ... while d*d <= n, with one bit-serial division per candidate d;
// n = 0 needs no division, and the final total can wait while the previous total is still unread.
// Each candidate d runs the check, division start, division wait and accumulate states.
// The next number is taken only once the total is parked in the output register.
// Reset: arst_n async, active low; clears the controller and output valid, idle after.
module divisor_sum_trial_division #(
	parameter int NUMBER_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	dst_in_if.sink           req,
	dst_out_if.source        rsp
);
	import dst_pkg::*;

	`include "divisor_sum_trial_division_macros.svh"

	cmd_t    cmd;
	status_t sts;

	// Only the low NUMBER_BITS of the input word take part.
	logic [NUMBER_BITS-1:0] num_in;
	assign num_in = req.number[NUMBER_BITS-1:0];

	// Controller: walks d = 1, 2, ... while d*d <= n.
	dst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: each exact divisor d adds d and its cofactor n/d to the total.
	// The square d*d is kept incrementally, so no multiplier is needed.
	// The output register lets a new number enter while the last total waits.
	dst_datapath #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.number    (num_in),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_sum   (rsp.divisor_sum)
	);

	// Engine is busy the cycle after it takes a word.
	`DST_ASSERT_NEXT(a_busy_after_load, req.valid && req.ready, !req.ready, "took word while busy")
	// A result word appears only after the controller parks a total.
	`DST_ASSERT_NOW(a_out_from_fin, $rose(rsp.valid), $past(cmd.load_out), "spurious result word")
	// Division is not instant; done cannot follow start directly.
	`DST_ASSERT_NEXT(a_div_not_instant, cmd.start_div, !sts.div_done, "divider done too early")
endmodule
